/* rtl/acull_pkg.sv */
// shared types and constants for the box versus frustum cull core
`timescale 1ns / 1ps

package acull_pkg;

    localparam int COORD_W        = 32;
    localparam int SLOT_W         = 5;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int NUM_COEF       = 4;
    localparam int NUM_AXES       = 3;
    localparam int NUM_PLANES_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COEF_A = 0;
    localparam int COEF_B = 1;
    localparam int COEF_C = 2;
    localparam int COEF_D = 3;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TEST  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        coord_t            value;
    } plane_wr_t;

endpackage

/* rtl/acull_plane_table.sv */
// plane coefficient table, cleared at reset, one write port
`timescale 1ns / 1ps

module acull_plane_table #(
    parameter int NUM_PLANES = acull_pkg::NUM_PLANES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  acull_pkg::plane_wr_t wr,
    output acull_pkg::coord_t   coef [NUM_PLANES][acull_pkg::NUM_COEF]
);
    import acull_pkg::*;

    coord_t table_reg [NUM_PLANES][NUM_COEF];

    // slots beyond the table never match, so those writes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int k = 0; k < NUM_COEF; k++)
                begin
                    table_reg[p][k] <= '0;
                end
            end
        end
        else
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int k = 0; k < NUM_COEF; k++)
                begin
                    if (wr.en && (wr.slot == SLOT_W'(p * NUM_COEF + k)))
                    begin
                        table_reg[p][k] <= wr.value;
                    end
                end
            end
        end
    end

    assign coef = table_reg;

endmodule

/* rtl/acull_select_stage.sv */
// stage 1: per plane and axis, pick the box coordinate that maximizes the plane value
`timescale 1ns / 1ps

module acull_select_stage #(
    parameter int NUM_PLANES = acull_pkg::NUM_PLANES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  acull_pkg::coord_t lo [acull_pkg::NUM_AXES],
    input  acull_pkg::coord_t hi [acull_pkg::NUM_AXES],
    input  acull_pkg::coord_t coef [NUM_PLANES][acull_pkg::NUM_COEF],
    output logic              dn_valid,
    input  logic              dn_ready,
    output acull_pkg::coord_t sel [NUM_PLANES][acull_pkg::NUM_AXES],
    output acull_pkg::coord_t sel_coef [NUM_PLANES][acull_pkg::NUM_COEF]
);
    import acull_pkg::*;

    logic   valid_reg;
    coord_t big   [NUM_AXES];
    coord_t small_c [NUM_AXES];
    coord_t sel_next [NUM_PLANES][NUM_AXES];
    coord_t sel_reg  [NUM_PLANES][NUM_AXES];
    coord_t coef_reg [NUM_PLANES][NUM_COEF];

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            big[j]     = (lo[j] > hi[j]) ? lo[j] : hi[j];
            small_c[j] = (lo[j] > hi[j]) ? hi[j] : lo[j];
        end
        // non-negative coefficient wants the larger coordinate
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                sel_next[p][j] = coef[p][j][COORD_W-1] ? small_c[j] : big[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            sel_reg  <= sel_next;
            coef_reg <= coef;
        end
    end

    assign dn_valid = valid_reg;
    assign sel      = sel_reg;
    assign sel_coef = coef_reg;

    a_sel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(sel_reg[0][AXIS_X]))
        else $error("select stage lost a stalled word");

    a_sel_corner: assert property (@(posedge clk) disable iff (!rst_n)
        up_ready && up_valid |=>
            (sel_reg[0][AXIS_X] == $past(lo[AXIS_X]) || sel_reg[0][AXIS_X] == $past(hi[AXIS_X]))
         && (sel_reg[0][AXIS_Y] == $past(lo[AXIS_Y]) || sel_reg[0][AXIS_Y] == $past(hi[AXIS_Y]))
         && (sel_reg[0][AXIS_Z] == $past(lo[AXIS_Z]) || sel_reg[0][AXIS_Z] == $past(hi[AXIS_Z])))
        else $error("selected coordinate is not a box corner value");

endmodule

/* rtl/acull_mult_stage.sv */
// stage 2: full-width coefficient products and scaled offset term
`timescale 1ns / 1ps

module acull_mult_stage #(
    parameter int NUM_PLANES = acull_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = acull_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  acull_pkg::coord_t sel [NUM_PLANES][acull_pkg::NUM_AXES],
    input  acull_pkg::coord_t coef [NUM_PLANES][acull_pkg::NUM_COEF],
    output logic              dn_valid,
    input  logic              dn_ready,
    output acull_pkg::prod_t  prod [NUM_PLANES][acull_pkg::NUM_AXES],
    output acull_pkg::sum_t   dterm [NUM_PLANES]
);
    import acull_pkg::*;

    logic  valid_reg;
    prod_t prod_next  [NUM_PLANES][NUM_AXES];
    prod_t prod_reg   [NUM_PLANES][NUM_AXES];
    sum_t  dterm_next [NUM_PLANES];
    sum_t  dterm_reg  [NUM_PLANES];

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                prod_next[p][j] = prod_t'(coef[p][j]) * prod_t'(sel[p][j]);
            end
            dterm_next[p] = sum_t'(coef[p][COEF_D]) <<< FRAC_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            prod_reg  <= prod_next;
            dterm_reg <= dterm_next;
        end
    end

    assign dn_valid = valid_reg;
    assign prod     = prod_reg;
    assign dterm    = dterm_reg;

    a_mult_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(dterm_reg[0]))
        else $error("multiply stage lost a stalled word");

endmodule

/* rtl/acull_sum_stage.sv */
// stage 3: plane sums, sign test and output register
`timescale 1ns / 1ps

module acull_sum_stage #(
    parameter int NUM_PLANES = acull_pkg::NUM_PLANES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  acull_pkg::prod_t prod [NUM_PLANES][acull_pkg::NUM_AXES],
    input  acull_pkg::sum_t  dterm [NUM_PLANES],
    output logic             out_valid,
    input  logic             out_stall,
    output logic             box_visible
);
    import acull_pkg::*;

    logic                  valid_reg;
    logic                  visible_reg;
    logic                  visible_next;
    sum_t                  plane_sum [NUM_PLANES];
    logic [NUM_PLANES-1:0] reject;

    assign up_ready = !valid_reg || !out_stall;

    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_sum[p] = sum_t'(prod[p][AXIS_X]) + sum_t'(prod[p][AXIS_Y])
                         + sum_t'(prod[p][AXIS_Z]) + dterm[p];
            reject[p]    = plane_sum[p][SUM_W-1];
        end
        visible_next = ~|reject;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            visible_reg <= visible_next;
        end
    end

    assign out_valid   = valid_reg;
    assign box_visible = visible_reg;

    a_sum_load: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready |=> out_valid)
        else $error("result word dropped at output register");

endmodule

/* rtl/aabb_frustum_cull_core.sv */
// top level of the axis-aligned box versus view frustum cull core
`timescale 1ns / 1ps

// Takes one word per cycle while in_stall is low. A word with mode 0 writes
// one plane coefficient (slot = plane * 4 + a/b/c/d) and gives no result;
// the write is seen by the very next box. A word with mode 1 tests a box
// and gives one box_visible result, registered through the three register
// stages (coordinate select, multiply, sum and sign), with no gaps between
// boxes while out_stall is low; each plane uses three 32x32 multipliers in
// the multiply stage. Output stall holds the pipeline only as far back as
// its first empty stage. The plane table resets to zero, so every box is
// visible until planes are written.

module aabb_frustum_cull_core #(
    parameter int NUM_PLANES = acull_pkg::NUM_PLANES_DEF,
    parameter int FRAC_BITS  = acull_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [acull_pkg::SLOT_W-1:0]   coef_slot,
    input  acull_pkg::coord_t              coef_value,
    input  acull_pkg::coord_t              min_x,
    input  acull_pkg::coord_t              min_y,
    input  acull_pkg::coord_t              min_z,
    input  acull_pkg::coord_t              max_x,
    input  acull_pkg::coord_t              max_y,
    input  acull_pkg::coord_t              max_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           box_visible
);
    import acull_pkg::*;

    plane_wr_t wr;
    coord_t    coef      [NUM_PLANES][NUM_COEF];
    coord_t    lo        [NUM_AXES];
    coord_t    hi        [NUM_AXES];
    logic      s1_ready;
    logic      s1_valid;
    coord_t    s1_sel    [NUM_PLANES][NUM_AXES];
    coord_t    s1_coef   [NUM_PLANES][NUM_COEF];
    logic      s2_ready;
    logic      s2_valid;
    prod_t     s2_prod   [NUM_PLANES][NUM_AXES];
    sum_t      s2_dterm  [NUM_PLANES];
    logic      s3_ready;

    assign in_stall = !s1_ready;

    assign wr.en    = in_valid && s1_ready && (mode == MODE_WRITE);
    assign wr.slot  = coef_slot;
    assign wr.value = coef_value;

    assign lo[AXIS_X] = min_x;
    assign lo[AXIS_Y] = min_y;
    assign lo[AXIS_Z] = min_z;
    assign hi[AXIS_X] = max_x;
    assign hi[AXIS_Y] = max_y;
    assign hi[AXIS_Z] = max_z;

    acull_plane_table #(
        .NUM_PLANES (NUM_PLANES)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .coef  (coef)
    );

    acull_select_stage #(
        .NUM_PLANES (NUM_PLANES)
    ) u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid && (mode == MODE_TEST)),
        .up_ready (s1_ready),
        .lo       (lo),
        .hi       (hi),
        .coef     (coef),
        .dn_valid (s1_valid),
        .dn_ready (s2_ready),
        .sel      (s1_sel),
        .sel_coef (s1_coef)
    );

    acull_mult_stage #(
        .NUM_PLANES (NUM_PLANES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s2_ready),
        .sel      (s1_sel),
        .coef     (s1_coef),
        .dn_valid (s2_valid),
        .dn_ready (s3_ready),
        .prod     (s2_prod),
        .dterm    (s2_dterm)
    );

    acull_sum_stage #(
        .NUM_PLANES (NUM_PLANES)
    ) u_sum (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (s2_valid),
        .up_ready    (s3_ready),
        .prod        (s2_prod),
        .dterm       (s2_dterm),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .box_visible (box_visible)
    );

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid && s2_valid && out_valid)
        else $error("input stalled while the pipeline has an empty stage");

endmodule
